// ===== hw/rtl/aecrl_pkg.sv =====
// Package for the AEC reference loopback FIFO.
// Holds ring geometry, command codes, the result type and pointer helpers.
// No dependencies.
package aecrl_pkg;

    localparam int DEPTH  = 4096;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = 13;
    localparam int SMP_W  = 16;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_MIC  = 1'b1;

    localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(DEPTH);

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] mic_sample;
        logic signed [SMP_W-1:0] ref_sample;
        logic                    ref_missing;
        logic                    frame_last;
        cnt_t                    fill_level;
    } result_t;

    // Step a ring pointer, wrapping at the configured capacity.
    function automatic ptr_t next_ptr(input ptr_t ptr, input cnt_t cap);
        logic [PTR_W:0] sum;
        begin
            sum = {1'b0, ptr} + 1'b1;
            if (CNT_W'(sum) >= cap)
                next_ptr = '0;
            else
                next_ptr = sum[PTR_W-1:0];
        end
    endfunction

    // Map a written capacity into 1..DEPTH.
    function automatic cnt_t clamp_cap(input cnt_t value);
        begin
            if (value == '0)
                clamp_cap = CNT_W'(1);
            else if (value > CAP_MAX)
                clamp_cap = CAP_MAX;
            else
                clamp_cap = value;
        end
    endfunction

endpackage

// ===== hw/rtl/aecrl_if.sv =====
// Channel interfaces of the AEC reference loopback FIFO: input items,
// result items and the capacity write channel. Depends on aecrl_pkg.
interface aecrl_req_if import aecrl_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    command;
    logic signed [SMP_W-1:0] sample;
    logic                    burst_last;

    modport source (output valid, command, sample, burst_last, input ready);
    modport sink   (input valid, command, sample, burst_last, output ready);
endinterface

interface aecrl_rsp_if import aecrl_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] mic_sample;
    logic signed [SMP_W-1:0] ref_sample;
    logic                    ref_missing;
    logic                    frame_last;
    logic [CNT_W-1:0]        fill_level;

    modport source (output valid, mic_sample, ref_sample, ref_missing, frame_last,
                    fill_level, input ready);
    modport sink   (input valid, mic_sample, ref_sample, ref_missing, frame_last,
                    fill_level, output ready);
endinterface

interface aecrl_cfg_if import aecrl_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] capacity;

    modport source (output valid, capacity, input ready);
    modport sink   (input valid, capacity, output ready);
endinterface

// ===== hw/rtl/aecrl_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module aecrl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/aec_reference_loopback_fifo_core.sv =====
// Top level of the AEC reference loopback FIFO: overwriting ring of reference
// samples in one RAM, paired with mic samples on pop.
// Depends on aecrl_pkg, aecrl_if.sv and aecrl_ram.
//
//   channel | dir | payload                                          | transfer when
//   req     | in  | command, sample, burst_last                      | valid && ready
//   rsp     | out | mic_sample, ref_sample, ref_missing, frame_last, | valid && ready
//           |     | fill_level                                       |
//   cfg     | in  | capacity                                         | valid && ready
//
// One item per cycle unless a stalled output backs up the read stage. A mic
// item reads the ring RAM in its accept cycle; its registered read data and
// the read stage register feed the output register. Pointers and fill count live in flip-flops.
// Reset empties the ring and sets capacity to DEPTH; no clearing pass.
// A stalled output holds one result in the read stage, then req.ready drops.
module aec_reference_loopback_fifo_core import aecrl_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    aecrl_req_if.sink    req,
    aecrl_rsp_if.source  rsp,
    aecrl_cfg_if.sink    cfg
);

    ptr_t    wr_ptr_reg, wr_ptr_next;
    ptr_t    rd_ptr_reg, rd_ptr_next;
    cnt_t    count_reg, count_next;
    cnt_t    cap_reg, cap_next;

    logic    s1_valid_reg, s1_valid_next;
    result_t s1_reg, s1_next;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;

    logic                    accept;
    logic                    is_mic;
    logic                    out_load;
    logic                    ram_wr_en;
    logic                    ram_rd_en;
    logic [SMP_W-1:0]        ram_rd_data;

    assign out_load  = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || out_load;
    assign cfg.ready = 1'b1;
    assign accept    = req.valid && req.ready;
    assign is_mic    = (req.command == CMD_MIC);
    assign ram_wr_en = accept && (req.command == CMD_PUSH);
    assign ram_rd_en = accept && is_mic;

    aecrl_ram #(
        .WIDTH (SMP_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (req.sample),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        cap_next    = cap_reg;
        if (cfg.valid)
        begin
            // New capacity: empty the ring
            cap_next    = clamp_cap(cfg.capacity);
            wr_ptr_next = '0;
            rd_ptr_next = '0;
            count_next  = '0;
        end
        else if (accept)
        begin
            if (!is_mic)
            begin
                wr_ptr_next = next_ptr(wr_ptr_reg, cap_reg);
                if (count_reg < cap_reg)
                    count_next = count_reg + 1'b1;
                else
                    rd_ptr_next = next_ptr(rd_ptr_reg, cap_reg);  // drop oldest
            end
            else if (count_reg != '0)
            begin
                rd_ptr_next = next_ptr(rd_ptr_reg, cap_reg);
                count_next  = count_reg - 1'b1;
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_next       = s1_reg;
        if (accept && is_mic)
        begin
            s1_valid_next          = 1'b1;
            s1_next.mic_sample     = req.sample;
            s1_next.ref_sample     = '0;
            s1_next.ref_missing    = (count_reg == '0);
            s1_next.frame_last     = req.burst_last;
            s1_next.fill_level     = count_next;
        end
        else if (out_load)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_next       = s1_reg;
            // Zero-pad the reference when the ring was empty
            out_next.ref_sample = s1_reg.ref_missing ? '0 : $signed(ram_rd_data);
        end
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            cap_reg       <= CAP_MAX;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
            cap_reg       <= cap_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg  <= s1_next;
        out_reg <= out_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.mic_sample  = out_reg.mic_sample;
    assign rsp.ref_sample  = out_reg.ref_sample;
    assign rsp.ref_missing = out_reg.ref_missing;
    assign rsp.frame_last  = out_reg.frame_last;
    assign rsp.fill_level  = out_reg.fill_level;

    // Distance from read to write pointer around the ring
    logic [CNT_W:0] ptr_span;
    assign ptr_span = (wr_ptr_reg >= rd_ptr_reg)
                    ? (CNT_W+1)'(wr_ptr_reg) - (CNT_W+1)'(rd_ptr_reg)
                    : (CNT_W+1)'(wr_ptr_reg) + (CNT_W+1)'(cap_reg)
                      - (CNT_W+1)'(rd_ptr_reg);

    a_count_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cap_reg)
        else $error("fill count exceeds capacity");

    a_ptrs_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W'(wr_ptr_reg) < cap_reg) && (CNT_W'(rd_ptr_reg) < cap_reg))
        else $error("ring pointer beyond capacity");

    a_span_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ptr_span == (CNT_W+1)'(count_reg))
        || ((count_reg == cap_reg) && (wr_ptr_reg == rd_ptr_reg)))
        else $error("pointer distance disagrees with fill count");

    a_mic_reaches_read_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_mic) |=> s1_valid_reg)
        else $error("mic transfer lost before read stage");

    a_stall_holds_read_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !rsp.ready) |-> !req.ready)
        else $error("input taken while read stage is blocked");

endmodule

// ===== dv/aecrl_checker.sv =====
// Scoreboard for the AEC reference loopback FIFO: mirrors the ring from observed
// transfers, predicts each mic pairing and compares it with the result channel.
// Depends on aecrl_pkg and the channel interfaces in aecrl_if.sv.
module aecrl_checker import aecrl_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    aecrl_req_if req,
    aecrl_rsp_if rsp,
    aecrl_cfg_if cfg,
    output int   fail_count,
    output int   pending
);

    logic signed [SMP_W-1:0] ring_mem [DEPTH];
    ptr_t                    wr_ptr;
    ptr_t                    rd_ptr;
    cnt_t                    level;
    cnt_t                    cap;
    result_t                 pairs_due[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic cnt_t legal_capacity(input cnt_t value);
        if (value == '0)
            return cnt_t'(1);
        if (value > cnt_t'(DEPTH))
            return cnt_t'(DEPTH);
        return value;
    endfunction

    function automatic ptr_t ring_bump(input ptr_t p);
        int n;
        n = int'(p) + 1;
        if (n >= int'(cap))
            return '0;
        return ptr_t'(n);
    endfunction

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            wr_ptr = '0;
            rd_ptr = '0;
            level  = '0;
            cap    = cnt_t'(DEPTH);
            pairs_due.delete();
            pending <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pairs_due.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual mic %0d ref %0d",
                             $time, rsp.mic_sample, rsp.ref_sample);
                    fail_count++;
                end
                else
                begin
                    want = pairs_due.pop_front();
                    check_field("mic_sample", want.mic_sample, rsp.mic_sample);
                    check_field("ref_sample", want.ref_sample, rsp.ref_sample);
                    check_field("ref_missing", {31'd0, want.ref_missing},
                                {31'd0, rsp.ref_missing});
                    check_field("frame_last", {31'd0, want.frame_last},
                                {31'd0, rsp.frame_last});
                    check_field("fill_level", {19'd0, want.fill_level},
                                {19'd0, rsp.fill_level});
                end
            end

            // A capacity write empties the ring.
            if (cfg.valid && cfg.ready)
            begin
                cap    = legal_capacity(cfg.capacity);
                wr_ptr = '0;
                rd_ptr = '0;
                level  = '0;
            end

            if (req.valid && req.ready)
            begin
                if (req.command == CMD_PUSH)
                begin
                    ring_mem[wr_ptr] = req.sample;
                    wr_ptr = ring_bump(wr_ptr);
                    // Full ring: drop the oldest sample along with the write.
                    if (level < cap)
                        level++;
                    else
                        rd_ptr = ring_bump(rd_ptr);
                end
                else
                begin
                    want.mic_sample = req.sample;
                    want.frame_last = req.burst_last;
                    if (level == '0)
                    begin
                        want.ref_sample  = '0;
                        want.ref_missing = 1'b1;
                    end
                    else
                    begin
                        want.ref_sample  = ring_mem[rd_ptr];
                        want.ref_missing = 1'b0;
                        rd_ptr = ring_bump(rd_ptr);
                        level--;
                    end
                    want.fill_level = level;
                    pairs_due.push_back(want);
                end
            end
            pending <= pairs_due.size();
        end
    end

endmodule

// ===== dv/tb_aec_reference_loopback_fifo_core.sv =====
// Testbench top for the AEC reference loopback FIFO: drives pushes, mic samples
// and capacity writes with random gaps and stalls, and gives the verdict.
// Depends on aecrl_pkg, aecrl_if.sv, aecrl_checker and the core RTL.
module tb_aec_reference_loopback_fifo_core;
    import aecrl_pkg::*;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    bit   steady;
    int   press_cycles;
    int   n_items;
    int   n_mic;
    int   n_caps;
    int   cap_plan[12] = '{1, 0, 2, 3, 8191, 4097, 7, 16, 4096, 100, 5, 2048};

    aecrl_req_if req_ch ();
    aecrl_rsp_if rsp_ch ();
    aecrl_cfg_if cfg_ch ();

    aec_reference_loopback_fifo_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    aecrl_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #(12 * 2000000);
        $display("tb_aec_reference_loopback_fifo_core NOT OK");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [SMP_W-1:0] rand_sample();
        case ($urandom_range(0, 15))
            0:       return SMP_W'(16'h8000);
            1:       return SMP_W'(16'h7FFF);
            2:       return '0;
            3:       return '1;
            default: return SMP_W'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic cmd, input logic signed [SMP_W-1:0] smp,
                             input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.command    <= cmd;
        req_ch.sample     <= smp;
        req_ch.burst_last <= last;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        n_items++;
        if (cmd == CMD_MIC)
            n_mic++;
    endtask

    // Drain: wait for every pairing, then let any push still in flight land.
    task automatic settle();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_capacity(input int value);
        settle();
        cfg_ch.capacity <= cnt_t'(value);
        cfg_ch.valid    <= 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        n_caps++;
    endtask

    task automatic run_random(input int count);
        int push_pct;
        push_pct = 50;
        for (int i = 0; i < count; i++)
        begin
            // Shift the push/mic balance so the ring both overflows and runs dry.
            if (i % 20 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 15;
                    1:       push_pct = 50;
                    default: push_pct = 85;
                endcase
            end
            if ($urandom_range(0, 99) < push_pct)
                send_item(CMD_PUSH, rand_sample(), 1'($urandom_range(0, 1)));
            else
                send_item(CMD_MIC, rand_sample(), 1'($urandom_range(0, 1)));
        end
    endtask

    // Receiver: random stalls, plus a long hold-off on request.
    initial
    begin
        int stall;
        int hold;
        stall = 0;
        hold  = 0;
        forever
        begin
            @(posedge clk);
            if (press_cycles > 0)
            begin
                hold         = press_cycles;
                press_cycles = 0;
            end
            if (hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold--;
            end
            else if (steady)
                rsp_ch.ready <= 1'b1;
            else if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < 20)
                    stall = pick_gap();
            end
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        steady            = 1'b0;
        press_cycles      = 0;
        n_items           = 0;
        n_mic             = 0;
        n_caps            = 0;
        req_ch.valid      = 1'b0;
        req_ch.command    = CMD_PUSH;
        req_ch.sample     = '0;
        req_ch.burst_last = 1'b0;
        rsp_ch.ready      = 1'b1;
        cfg_ch.valid      = 1'b0;
        cfg_ch.capacity   = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset capacity: mic on an empty ring, sample extremes, drain to empty.
        send_item(CMD_MIC, SMP_W'(16'h8000), 1'b0);
        send_item(CMD_MIC, SMP_W'(16'h7FFF), 1'b1);
        send_item(CMD_PUSH, SMP_W'(16'h7FFF), 1'b1);
        send_item(CMD_PUSH, SMP_W'(16'h8000), 1'b0);
        send_item(CMD_PUSH, '0, 1'b0);
        send_item(CMD_PUSH, '1, 1'b1);
        send_item(CMD_MIC, '0, 1'b0);
        send_item(CMD_MIC, '1, 1'b1);
        send_item(CMD_MIC, SMP_W'(1), 1'b0);
        send_item(CMD_MIC, SMP_W'(16'h5555), 1'b1);
        send_item(CMD_MIC, SMP_W'(16'hAAAA), 1'b0);

        foreach (cap_plan[p])
        begin
            write_capacity(cap_plan[p]);
            if (cap_plan[p] == 1)
            begin
                // Single entry: second push overwrites the first.
                send_item(CMD_PUSH, SMP_W'(100), 1'b0);
                send_item(CMD_PUSH, SMP_W'(-200), 1'b1);
                send_item(CMD_MIC, SMP_W'(300), 1'b1);
                send_item(CMD_MIC, SMP_W'(-400), 1'b0);
                run_random(115);
            end
            else if (cap_plan[p] == 8191)
            begin
                // Oversize write clamps to the full ring; run it back to back.
                steady = 1'b1;
                for (int i = 0; i < 40; i++)
                    send_item(CMD_PUSH, rand_sample(), 1'($urandom_range(0, 1)));
                for (int i = 0; i < 30; i++)
                    send_item(CMD_MIC, rand_sample(), 1'($urandom_range(0, 1)));
                run_random(115);
                steady = 1'b0;
            end
            else if (cap_plan[p] == 100)
            begin
                for (int i = 0; i < 60; i++)
                    send_item(CMD_PUSH, rand_sample(), 1'($urandom_range(0, 1)));
                // Hold the output off while mic samples keep coming.
                press_cycles = 300;
                for (int i = 0; i < 80; i++)
                    send_item(CMD_MIC, rand_sample(), 1'($urandom_range(0, 1)));
                run_random(115);
            end
            else
                run_random(115);
        end

        write_capacity($urandom_range(1, 300));
        run_random(115);
        settle();

        $display("Sent %0d items (%0d mic pairings) over %0d capacity settings,", n_items,
                 n_mic, n_caps);
        $display("from a single entry up to the clamped maximum, with overwrite, empty pops "
                 , "and stalls.");
        if (fail_count == 0)
            $display("tb_aec_reference_loopback_fifo_core OK");
        else
            $display("tb_aec_reference_loopback_fifo_core NOT OK");
        $finish;
    end

endmodule
